### rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define RWR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is high
`define RWR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rwr_pkg.sv
// types and constants of the reorder window receiver
// no dependencies
package rwr_pkg;

  localparam int WINDOW       = 4;
  localparam int SEQ_BITS     = 3;
  localparam int SLOT_BITS    = 2;
  localparam int PAYLOAD_BITS = 32;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  typedef struct packed {
    logic                    checksum_ok;
    logic [SEQ_BITS-1:0]     seq_num;
    logic [PAYLOAD_BITS-1:0] payload;
  } pkt_t;

  typedef struct packed {
    logic                    kind;
    logic [PAYLOAD_BITS-1:0] data_out;
    logic [SEQ_BITS-1:0]     ack_num;
    logic                    last;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND,
    ST_ACK
  } state_t;

  typedef struct packed {
    logic                    we;
    logic [SLOT_BITS-1:0]    waddr;
    logic [PAYLOAD_BITS-1:0] wdata;
    logic                    re;
    logic [SLOT_BITS-1:0]    raddr;
  } mem_req_t;

  typedef struct packed {
    logic load;
    res_t res;
  } out_req_t;

endpackage

### rtl/rwr_slot_mem.sv
// reorder slot payload memory, one write and one registered read port
// depends on rwr_pkg
module rwr_slot_mem (
  input  logic                             clk,
  input  rwr_pkg::mem_req_t                req,
  output logic [rwr_pkg::PAYLOAD_BITS-1:0] rd_data
);

  logic [rwr_pkg::PAYLOAD_BITS-1:0] mem [rwr_pkg::WINDOW];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

### rtl/rwr_out_reg.sv
// output register holding one result transaction until taken
// depends on rwr_pkg
module rwr_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  rwr_pkg::out_req_t req,
  output logic              free,
  output logic              res_valid,
  input  logic              res_ready,
  output rwr_pkg::res_t     res
);

  assign free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (req.load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      res <= req.res;
    end
  end

endmodule

### rtl/rwr_ctrl.sv
// receive control: window check, present flags, base, drain sequencer
// depends on rwr_pkg
module rwr_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pkt_valid,
  output logic                             pkt_ready,
  input  rwr_pkg::pkt_t                    pkt,
  output rwr_pkg::mem_req_t                mem_req,
  input  logic [rwr_pkg::PAYLOAD_BITS-1:0] rd_data,
  input  logic                             out_free,
  output rwr_pkg::out_req_t                out_req
);

  rwr_pkg::state_t                state, state_next;
  logic [rwr_pkg::WINDOW-1:0]     present;
  logic [rwr_pkg::SEQ_BITS-1:0]   base;
  logic [rwr_pkg::SEQ_BITS-1:0]   last_ack;

  logic                           accept;
  logic [rwr_pkg::SEQ_BITS-1:0]   offset;
  logic                           store;
  logic                           in_order;
  logic [rwr_pkg::SLOT_BITS-1:0]  slot;
  logic [rwr_pkg::SLOT_BITS-1:0]  base_slot;
  logic                           can_issue;
  logic                           issue;
  logic                           finish;

  assign slot      = pkt.seq_num[rwr_pkg::SLOT_BITS-1:0];
  assign base_slot = base[rwr_pkg::SLOT_BITS-1:0];
  assign offset    = pkt.seq_num - base;

  // outputs and strobes
  always_comb begin
    pkt_ready = (state == rwr_pkg::ST_IDLE);
    accept    = pkt_valid && pkt_ready;
    store     = accept && pkt.checksum_ok &&
                (offset < rwr_pkg::SEQ_BITS'(rwr_pkg::WINDOW));
    in_order  = store && (pkt.seq_num == base);

    can_issue = (state == rwr_pkg::ST_READ) ||
                ((state == rwr_pkg::ST_SEND) && out_free);
    issue     = can_issue && present[base_slot];
    finish    = can_issue && !present[base_slot];

    mem_req.we    = store;
    mem_req.waddr = slot;
    mem_req.wdata = pkt.payload;
    mem_req.re    = issue;
    mem_req.raddr = base_slot;

    out_req.load = out_free &&
                   ((state == rwr_pkg::ST_SEND) || (state == rwr_pkg::ST_ACK));
    if (state == rwr_pkg::ST_SEND) begin
      out_req.res.kind     = rwr_pkg::KIND_DATA;
      out_req.res.data_out = rd_data;
      out_req.res.ack_num  = '0;
      out_req.res.last     = 1'b0;
    end else begin
      out_req.res.kind     = rwr_pkg::KIND_ACK;
      out_req.res.data_out = '0;
      out_req.res.ack_num  = last_ack;
      out_req.res.last     = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rwr_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = in_order ? rwr_pkg::ST_READ : rwr_pkg::ST_ACK;
        end
      end
      rwr_pkg::ST_READ: begin
        state_next = present[base_slot] ? rwr_pkg::ST_SEND : rwr_pkg::ST_ACK;
      end
      rwr_pkg::ST_SEND: begin
        if (out_free) begin
          state_next = present[base_slot] ? rwr_pkg::ST_SEND : rwr_pkg::ST_ACK;
        end
      end
      rwr_pkg::ST_ACK: begin
        if (out_free) begin
          state_next = rwr_pkg::ST_IDLE;
        end
      end
      default: state_next = rwr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rwr_pkg::ST_IDLE;
      present  <= '0;
      base     <= '0;
      last_ack <= '0;
    end else begin
      state <= state_next;
      if (store) begin
        present[slot] <= 1'b1;
      end
      if (issue) begin
        present[base_slot] <= 1'b0;
        base               <= base + 1'b1;
      end
      if (finish) begin
        last_ack <= base;
      end
    end
  end

endmodule

### rtl/reorder_window_receiver_top.sv
// top level of the reorder window receiver
// depends on rwr_pkg, rwr_ctrl, rwr_slot_mem, rwr_out_reg
//
// Selective-repeat receiver with cumulative acknowledgement over a window
// of four slots and sequence numbers modulo eight. Each packet transaction
// yields zero to four in-order payload deliveries followed by one
// acknowledgement marked last. A packet that is corrupt, out of window or
// out of order passes through accept and acknowledgement; an in-order
// packet passes through accept, first read, one delivery per cycle while
// the result side does not stall, and acknowledgement, paced by the single
// read port of the slot memory. The next packet is accepted while the
// acknowledgement still waits in the output register.
module reorder_window_receiver_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          pkt_valid,
  output logic          pkt_ready,
  input  rwr_pkg::pkt_t pkt,
  output logic          res_valid,
  input  logic          res_ready,
  output rwr_pkg::res_t res
);

  // controller to memory and output register
  rwr_pkg::mem_req_t                mem_req;
  rwr_pkg::out_req_t                out_req;
  logic [rwr_pkg::PAYLOAD_BITS-1:0] rd_data;
  logic                             out_free;

  // sequencer: window check, present flags, base and ack tracking
  rwr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .out_free  (out_free),
    .out_req   (out_req)
  );

  // payload store, read data lands in the cycle after the read is issued
  rwr_slot_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // result transaction register, decouples the two handshakes
  rwr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .req       (out_req),
    .free      (out_free),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

### rtl/rwr_checker.sv
// port-level checker for the reorder window receiver, bound to the top
// depends on rwr_pkg and assert_macros.svh
`include "assert_macros.svh"

module rwr_checker (
  input logic          clk,
  input logic          rst,
  input logic          pkt_valid,
  input logic          pkt_ready,
  input logic          res_valid,
  input logic          res_ready,
  input rwr_pkg::res_t res
);

  `RWR_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid, "result dropped")
  `RWR_ASSERT_NEXT(a_res_stable, clk, rst, res_valid && !res_ready, $stable(res), "result changed")
  `RWR_ASSERT_NEXT(a_busy_after_pkt, clk, rst, pkt_valid && pkt_ready, !pkt_ready, "no busy cycle")
  `RWR_ASSERT_IMPL(a_ack_shape, clk, rst, res_valid, (res.kind == rwr_pkg::KIND_ACK) == res.last && (res.kind == rwr_pkg::KIND_ACK ? res.data_out == '0 : res.ack_num == '0), "bad result shape")

endmodule

bind reorder_window_receiver_top rwr_checker u_rwr_checker (.*);
